// ===== hdl/fmp_pkg.sv =====
// Shared types, widths and helpers for the field matrix power unit.
package fmp_pkg;

  localparam int DIM          = 3;
  localparam int ELEM_W       = 8;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int EXP_BITS_DEF = 16;
  // Barrett reciprocal: floor(2^RECIP_SHIFT / modulus)
  localparam int RECIP_SHIFT  = 22;
  localparam int RECIP_W      = 22;
  // Largest scalar product magnitude is 128*128*127, below 2^21.
  localparam int MAG_W        = 21;
  localparam int ABS_W        = 8;
  localparam int PROD_W       = 2 * ABS_W;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W_SQUARE = 2'd1;

  localparam logic [CFG_W-1:0] PRIME_RESET  = 7'd2;
  localparam logic [CFG_W-1:0] PRIME_MIN    = 7'd2;
  localparam logic [CFG_W-1:0] WSQ_RESET    = 7'd0;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [CFG_W-1:0]   modulus;
    logic [CFG_W-1:0]   w_square;
    logic [RECIP_W-1:0] recip;
  } field_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LEAD = 6'b000010,
    ST_LOOP = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // Magnitude of a signed entry; the most negative code gives 128.
  function automatic logic [ABS_W-1:0] mag_of(input elem_t v);
    logic [ABS_W-1:0] u;
    u = v;
    return v[ELEM_W-1] ? ABS_W'(~u + 1'b1) : u;
  endfunction

endpackage

// ===== hdl/field_matrix_power_unit.sv =====
// Top level of the field matrix power unit: sequencer, lanes and config.
//
// Raises a 3x3 matrix over a small prime field (entries may stand for multiples of w,
// with w*w = w_square) to the power given by exponent, low exponent bit first.
// Input channel: in_valid/in_stall with the nine entries and the exponent; an
// item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with the nine result entries.
// Config channel: cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data;
// index 0 is prime, index 1 is w_square, other indexes are ignored.
// Each matrix product is an issue state followed by the five-stage
// entry lanes (magnitude product, w_square product, Barrett quotient, remainder,
// sum reduction). Nine lanes form all entries of one product at once.
// An exponent of zero gives the identity without any matrix product. One item is
// worked on at a time. After reset, and after every write to prime, the reciprocal
// of the modulus is rebuilt bit by bit, and in_stall stays high meanwhile.
// A finished result waits in the output register while a new item may be taken;
// if the receiver still stalls when the next result is done, hold it in the
// sequencer until the output register frees up.
module field_matrix_power_unit #(
  parameter int EXP_BITS = fmp_pkg::EXP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fmp_pkg::elem_t                in_00,
  input  fmp_pkg::elem_t                in_01,
  input  fmp_pkg::elem_t                in_02,
  input  fmp_pkg::elem_t                in_10,
  input  fmp_pkg::elem_t                in_11,
  input  fmp_pkg::elem_t                in_12,
  input  fmp_pkg::elem_t                in_20,
  input  fmp_pkg::elem_t                in_21,
  input  fmp_pkg::elem_t                in_22,
  input  logic [EXP_BITS-1:0]           exponent,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fmp_pkg::elem_t                out_00,
  output fmp_pkg::elem_t                out_01,
  output fmp_pkg::elem_t                out_02,
  output fmp_pkg::elem_t                out_10,
  output fmp_pkg::elem_t                out_11,
  output fmp_pkg::elem_t                out_12,
  output fmp_pkg::elem_t                out_20,
  output fmp_pkg::elem_t                out_21,
  output fmp_pkg::elem_t                out_22,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DIM = fmp_pkg::DIM;

  fmp_pkg::state_t state;

  logic [fmp_pkg::CFG_W-1:0]   prime;
  logic [fmp_pkg::CFG_W-1:0]   w_square;
  logic [fmp_pkg::CFG_W-1:0]   modulus;
  logic [fmp_pkg::RECIP_W-1:0] recip;
  logic                        recip_busy;
  logic                        prime_write;
  fmp_pkg::field_t             field;

  logic [EXP_BITS-1:0]         shift;
  logic                        lead;
  logic                        mul_pass;

  fmp_pkg::elem_t mat     [DIM][DIM];
  fmp_pkg::elem_t res     [DIM][DIM];
  fmp_pkg::elem_t out_mat [DIM][DIM];
  fmp_pkg::elem_t in_mat  [DIM][DIM];

  fmp_pkg::elem_t lane_row   [DIM][DIM];
  fmp_pkg::elem_t lane_col   [DIM][DIM];
  fmp_pkg::elem_t lane_entry [DIM][DIM];
  logic [DIM*DIM-1:0] lane_done;

  logic prod_start;
  logic use_res;
  logic prod_done;

  assign cfg_ready   = 1'b1;
  assign prime_write = cfg_valid && cfg_ready && (cfg_index == fmp_pkg::REG_PRIME);

  // A prime below two acts as two.
  assign modulus = (prime < fmp_pkg::PRIME_MIN) ? fmp_pkg::PRIME_MIN : prime;

  assign field.modulus  = modulus;
  assign field.w_square = w_square;
  assign field.recip    = recip;

  fmp_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (prime_write),
    .divisor (modulus),
    .busy    (recip_busy),
    .recip   (recip)
  );

  assign in_stall = (state != fmp_pkg::ST_IDLE) || recip_busy;

  assign in_mat[0][0] = in_00;
  assign in_mat[0][1] = in_01;
  assign in_mat[0][2] = in_02;
  assign in_mat[1][0] = in_10;
  assign in_mat[1][1] = in_11;
  assign in_mat[1][2] = in_12;
  assign in_mat[2][0] = in_20;
  assign in_mat[2][1] = in_21;
  assign in_mat[2][2] = in_22;

  // Issue a squaring from LEAD or LOOP, a multiply of the running result from MUL.
  assign prod_start = ((state == fmp_pkg::ST_LEAD) && !shift[0]) ||
                      ((state == fmp_pkg::ST_LOOP) && (shift != '0)) ||
                      (state == fmp_pkg::ST_MUL);
  assign use_res    = (state == fmp_pkg::ST_MUL);
  assign prod_done  = &lane_done;

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        lane_row[i][j] = use_res ? res[i][j] : mat[i][j];
        lane_col[i][j] = mat[j][i];
      end
    end
  end

  for (genvar gi = 0; gi < DIM; gi++) begin : g_row
    for (genvar gk = 0; gk < DIM; gk++) begin : g_col
      fmp_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .start (prod_start),
        .field (field),
        .row   (lane_row[gi]),
        .col   (lane_col[gk]),
        .done  (lane_done[gi*DIM+gk]),
        .entry (lane_entry[gi][gk])
      );
    end
  end

  // Sequencer and config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fmp_pkg::ST_IDLE;
      out_valid <= 1'b0;
      prime     <= fmp_pkg::PRIME_RESET;
      w_square  <= fmp_pkg::WSQ_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fmp_pkg::REG_PRIME:    prime    <= cfg_data;
          fmp_pkg::REG_W_SQUARE: w_square <= cfg_data;
          default: ;
        endcase
      end

      // DONE reloads the output register itself.
      if (out_valid && !out_stall && (state != fmp_pkg::ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        fmp_pkg::ST_IDLE: begin
          if (in_valid && !in_stall) begin
            mat   <= in_mat;
            shift <= exponent;
            lead  <= 1'b1;
            if (exponent == '0) begin
              for (int i = 0; i < DIM; i++) begin
                for (int j = 0; j < DIM; j++) begin
                  res[i][j] <= (i == j) ? fmp_pkg::elem_t'(1) : fmp_pkg::elem_t'(0);
                end
              end
              state <= fmp_pkg::ST_DONE;
            end else begin
              state <= fmp_pkg::ST_LEAD;
            end
          end
        end
        fmp_pkg::ST_LEAD: begin
          // First one bit: the current matrix becomes the running result.
          if (shift[0]) begin
            res   <= mat;
            shift <= shift >> 1;
            lead  <= 1'b0;
            state <= fmp_pkg::ST_LOOP;
          end else begin
            mul_pass <= 1'b0;
            state    <= fmp_pkg::ST_WAIT;
          end
        end
        fmp_pkg::ST_LOOP: begin
          if (shift == '0) begin
            state <= fmp_pkg::ST_DONE;
          end else begin
            mul_pass <= 1'b0;
            state    <= fmp_pkg::ST_WAIT;
          end
        end
        fmp_pkg::ST_MUL: begin
          mul_pass <= 1'b1;
          state    <= fmp_pkg::ST_WAIT;
        end
        fmp_pkg::ST_WAIT: begin
          if (prod_done) begin
            if (mul_pass) begin
              res   <= lane_entry;
              shift <= shift >> 1;
              state <= fmp_pkg::ST_LOOP;
            end else begin
              mat <= lane_entry;
              if (lead) begin
                shift <= shift >> 1;
                state <= fmp_pkg::ST_LEAD;
              end else if (shift[0]) begin
                state <= fmp_pkg::ST_MUL;
              end else begin
                shift <= shift >> 1;
                state <= fmp_pkg::ST_LOOP;
              end
            end
          end
        end
        fmp_pkg::ST_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || !out_stall) begin
            out_mat   <= res;
            out_valid <= 1'b1;
            state     <= fmp_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= fmp_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign out_00 = out_mat[0][0];
  assign out_01 = out_mat[0][1];
  assign out_02 = out_mat[0][2];
  assign out_10 = out_mat[1][0];
  assign out_11 = out_mat[1][1];
  assign out_12 = out_mat[1][2];
  assign out_20 = out_mat[2][0];
  assign out_21 = out_mat[2][1];
  assign out_22 = out_mat[2][2];

endmodule

// ===== hdl/fmp_recip.sv =====
// Bit-serial divider that forms the Barrett reciprocal of the modulus.
module fmp_recip (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fmp_pkg::CFG_W-1:0]   divisor,
  output logic                        busy,
  output logic [fmp_pkg::RECIP_W-1:0] recip
);

  localparam int STEPS = fmp_pkg::RECIP_SHIFT + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic [CNT_W-1:0]          cnt;
  logic [fmp_pkg::CFG_W-1:0] rem;
  logic [fmp_pkg::CFG_W:0]   part;
  logic [fmp_pkg::CFG_W:0]   part_next;
  logic                      ge;
  logic                      last;

  // Dividend is a single one at the top bit followed by zeros.
  always_comb begin
    part      = {rem, (cnt == '0)};
    ge        = (part >= {1'b0, divisor});
    part_next = ge ? (part - {1'b0, divisor}) : part;
    last      = (cnt == CNT_W'(STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
    end else if (busy) begin
      rem   <= part_next[fmp_pkg::CFG_W-1:0];
      recip <= {recip[fmp_pkg::RECIP_W-2:0], ge};
      cnt   <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/fmp_lane.sv =====
// One entry lane: three field products, summed and reduced over five stages.
module fmp_lane (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fmp_pkg::field_t field,
  input  fmp_pkg::elem_t  row [fmp_pkg::DIM],
  input  fmp_pkg::elem_t  col [fmp_pkg::DIM],
  output logic            done,
  output fmp_pkg::elem_t  entry
);

  localparam int DIM   = fmp_pkg::DIM;
  localparam int MAG_W = fmp_pkg::MAG_W;
  localparam int CFG_W = fmp_pkg::CFG_W;
  localparam int WP_W  = fmp_pkg::PROD_W + CFG_W;
  localparam int BQ_W  = MAG_W + fmp_pkg::RECIP_W;
  localparam int QP_W  = MAG_W + CFG_W;
  localparam int SUM_W = fmp_pkg::ELEM_W + 2;

  logic [4:0] vld;

  logic [fmp_pkg::PROD_W-1:0] mag1 [DIM];
  logic                       neg1 [DIM];
  logic                       both1 [DIM];
  logic [MAG_W-1:0]           mag2 [DIM];
  logic                       neg2 [DIM];
  logic [MAG_W-1:0]           mag3 [DIM];
  logic [MAG_W-1:0]           quo3 [DIM];
  logic                       neg3 [DIM];
  fmp_pkg::elem_t             term [DIM];

  logic [WP_W-1:0]            wprod [DIM];
  logic [BQ_W-1:0]            bq    [DIM];
  logic [QP_W-1:0]            qp    [DIM];
  logic [MAG_W-1:0]           diff  [DIM];
  logic [CFG_W:0]             rfix  [DIM];
  logic [fmp_pkg::ELEM_W-1:0] tmag  [DIM];

  logic [SUM_W-1:0]           sum;
  logic [SUM_W-2:0]           smag;
  logic [SUM_W-2:0]           sred1;
  logic [SUM_W-2:0]           sred2;
  logic [fmp_pkg::ELEM_W-1:0] emag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  assign done = vld[4];

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      wprod[j] = WP_W'(mag1[j]) * WP_W'(field.w_square);
      bq[j]    = BQ_W'(mag2[j]) * BQ_W'(field.recip);
      qp[j]    = QP_W'(quo3[j]) * QP_W'(field.modulus);
      diff[j]  = mag3[j] - qp[j][MAG_W-1:0];
      // Barrett leaves at most one extra modulus.
      rfix[j]  = (diff[j][CFG_W:0] >= {1'b0, field.modulus}) ?
                 (diff[j][CFG_W:0] - {1'b0, field.modulus}) : diff[j][CFG_W:0];
      tmag[j]  = {1'b0, rfix[j][CFG_W-1:0]};
    end
    sum = '0;
    for (int j = 0; j < DIM; j++) begin
      sum = sum + {{2{term[j][fmp_pkg::ELEM_W-1]}}, term[j]};
    end
    smag  = sum[SUM_W-1] ? (SUM_W-1)'(~sum + 1'b1) : sum[SUM_W-2:0];
    // Sum of three reduced terms stays below three times the modulus.
    sred1 = (smag >= (SUM_W-1)'(field.modulus)) ? (smag - (SUM_W-1)'(field.modulus)) : smag;
    sred2 = (sred1 >= (SUM_W-1)'(field.modulus)) ? (sred1 - (SUM_W-1)'(field.modulus)) : sred1;
    emag  = {1'b0, sred2[CFG_W-1:0]};
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIM; j++) begin
      mag1[j]  <= fmp_pkg::PROD_W'(fmp_pkg::mag_of(row[j])) *
                  fmp_pkg::PROD_W'(fmp_pkg::mag_of(col[j]));
      neg1[j]  <= row[j][fmp_pkg::ELEM_W-1] ^ col[j][fmp_pkg::ELEM_W-1];
      both1[j] <= row[j][fmp_pkg::ELEM_W-1] & col[j][fmp_pkg::ELEM_W-1];

      mag2[j]  <= both1[j] ? wprod[j][MAG_W-1:0] : MAG_W'(mag1[j]);
      neg2[j]  <= neg1[j];

      quo3[j]  <= bq[j][BQ_W-1:fmp_pkg::RECIP_SHIFT];
      mag3[j]  <= mag2[j];
      neg3[j]  <= neg2[j];

      term[j]  <= neg3[j] ? (~tmag[j] + 1'b1) : tmag[j];
    end
    entry <= sum[SUM_W-1] ? (~emag + 1'b1) : emag;
  end

endmodule

// ===== hdl/fmp_checker.sv =====
// Port-level checks for the field matrix power unit, bound to the top level.
module fmp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input fmp_pkg::elem_t                out_00,
  input fmp_pkg::elem_t                out_01,
  input fmp_pkg::elem_t                out_02,
  input fmp_pkg::elem_t                out_10,
  input fmp_pkg::elem_t                out_11,
  input fmp_pkg::elem_t                out_12,
  input fmp_pkg::elem_t                out_20,
  input fmp_pkg::elem_t                out_21,
  input fmp_pkg::elem_t                out_22,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [fmp_pkg::CFG_IDX_W-1:0] cfg_index
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_00) && $stable(out_01) &&
      $stable(out_02) && $stable(out_10) && $stable(out_11) && $stable(out_12) &&
      $stable(out_20) && $stable(out_21) && $stable(out_22))
    else $error("result changed while stalled");

  // One item at a time: an accepted item closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accept");

  // The reciprocal rebuild after reset keeps the input closed.
  a_reset_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open right after reset");

  // A prime write starts a reciprocal rebuild.
  a_prime_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == fmp_pkg::REG_PRIME) |=> in_stall)
    else $error("input open during reciprocal rebuild");

  // A new result only follows a cycle in which the unit was busy.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared from an idle unit");

endmodule

bind field_matrix_power_unit fmp_checker u_fmp_checker (.*);

// ===== tb/fmp_checker.sv =====
// Checker for the field matrix power unit: predicts each result item and compares it.
module fmp_scoreboard (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  fmp_pkg::elem_t                in_00,
  input  fmp_pkg::elem_t                in_01,
  input  fmp_pkg::elem_t                in_02,
  input  fmp_pkg::elem_t                in_10,
  input  fmp_pkg::elem_t                in_11,
  input  fmp_pkg::elem_t                in_12,
  input  fmp_pkg::elem_t                in_20,
  input  fmp_pkg::elem_t                in_21,
  input  fmp_pkg::elem_t                in_22,
  input  logic [fmp_pkg::EXP_BITS_DEF-1:0] exponent,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  fmp_pkg::elem_t                out_00,
  input  fmp_pkg::elem_t                out_01,
  input  fmp_pkg::elem_t                out_02,
  input  fmp_pkg::elem_t                out_10,
  input  fmp_pkg::elem_t                out_11,
  input  fmp_pkg::elem_t                out_12,
  input  fmp_pkg::elem_t                out_20,
  input  fmp_pkg::elem_t                out_21,
  input  fmp_pkg::elem_t                out_22,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmp_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBITS = fmp_pkg::EXP_BITS_DEF;

  typedef struct { int e [3][3]; } field_mat_t;
  typedef struct { fmp_pkg::elem_t e [3][3]; } power_mat_t;

  logic [fmp_pkg::CFG_W-1:0] prime_copy;
  logic [fmp_pkg::CFG_W-1:0] wsq_copy;
  power_mat_t                powers_q [$];
  power_mat_t                want;
  field_mat_t                src;
  field_mat_t                pw;
  fmp_pkg::elem_t            got [3][3];

  function automatic field_mat_t field_product(field_mat_t a, field_mat_t b, int md, int wsq);
    field_mat_t r;
    int         acc;
    int         p;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          p = a.e[i][j] * b.e[j][k];
          // two w-multiples give a w_square multiple
          if (a.e[i][j] < 0 && b.e[j][k] < 0) p = p * wsq;
          acc += p % md;
        end
        r.e[i][k] = acc % md;
      end
    end
    return r;
  endfunction

  function automatic field_mat_t field_power(field_mat_t m, logic [NBITS-1:0] n, int md,
                                             int wsq);
    field_mat_t res;
    int         b;
    if (n == '0) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          res.e[i][j] = (i == j) ? 1 : 0;
      return res;
    end
    b = 0;
    while (!n[b]) begin
      m = field_product(m, m, md, wsq);
      b++;
    end
    res = m;
    for (b = b + 1; b < NBITS; b++) begin
      if ((n >> b) == '0) break;
      m = field_product(m, m, md, wsq);
      if (n[b]) res = field_product(res, m, md, wsq);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prime_copy = fmp_pkg::PRIME_RESET;
      wsq_copy   = fmp_pkg::WSQ_RESET;
      powers_q.delete();
    end else begin
      // compare the result item against the oldest prediction
      if (out_valid && !out_stall) begin
        got[0][0] = out_00; got[0][1] = out_01; got[0][2] = out_02;
        got[1][0] = out_10; got[1][1] = out_11; got[1][2] = out_12;
        got[2][0] = out_20; got[2][1] = out_21; got[2][2] = out_22;
        if (powers_q.size() == 0) begin
          report_mismatch("result item with no item outstanding");
        end else begin
          want = powers_q.pop_front();
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              if (got[i][j] !== want.e[i][j])
                report_mismatch($sformatf("out_%0d%0d got %0d want %0d",
                                          i, j, got[i][j], want.e[i][j]));
        end
      end
      if (in_valid && !in_stall) begin
        src.e[0][0] = in_00; src.e[0][1] = in_01; src.e[0][2] = in_02;
        src.e[1][0] = in_10; src.e[1][1] = in_11; src.e[1][2] = in_12;
        src.e[2][0] = in_20; src.e[2][1] = in_21; src.e[2][2] = in_22;
        pw = field_power(src, exponent, (prime_copy < 2) ? 2 : int'(prime_copy),
                         int'(wsq_copy));
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            want.e[i][j] = fmp_pkg::elem_t'(pw.e[i][j]);
        powers_q.insert(powers_q.size(), want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fmp_pkg::REG_PRIME:    prime_copy = cfg_data;
          fmp_pkg::REG_W_SQUARE: wsq_copy   = cfg_data;
          default: ;
        endcase
      end
    end
    pending = powers_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the field matrix power unit testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block does not decode; writes must be no-ops.
  localparam logic [fmp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [fmp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // Cycles with no accepted item on any channel before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  // Worst-case accept-to-result latency of the block, plus margin.
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 210;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  fmp_pkg::elem_t                ent [3][3];
  logic [fmp_pkg::EXP_BITS_DEF-1:0] exp_val = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fmp_pkg::elem_t                out_00, out_01, out_02, out_10, out_11, out_12;
  fmp_pkg::elem_t                out_20, out_21, out_22;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fmp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fmp_pkg::CFG_W-1:0]     cfg_data  = '0;

  int   fail_count;
  int   pending;
  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;
  int   idle_cycles = 0;
  int   cur_md = 2;         // modulus in force, used to keep entries in range
  int   stall_pct = 0;
  int   stall_span = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  field_matrix_power_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_00    (ent[0][0]),
    .in_01    (ent[0][1]),
    .in_02    (ent[0][2]),
    .in_10    (ent[1][0]),
    .in_11    (ent[1][1]),
    .in_12    (ent[1][2]),
    .in_20    (ent[2][0]),
    .in_21    (ent[2][1]),
    .in_22    (ent[2][2]),
    .exponent (exp_val),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_00   (out_00),
    .out_01   (out_01),
    .out_02   (out_02),
    .out_10   (out_10),
    .out_11   (out_11),
    .out_12   (out_12),
    .out_20   (out_20),
    .out_21   (out_21),
    .out_22   (out_22),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fmp_scoreboard chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_00     (ent[0][0]),
    .in_01     (ent[0][1]),
    .in_02     (ent[0][2]),
    .in_10     (ent[1][0]),
    .in_11     (ent[1][1]),
    .in_12     (ent[1][2]),
    .in_20     (ent[2][0]),
    .in_21     (ent[2][1]),
    .in_22     (ent[2][2]),
    .exponent  (exp_val),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_00    (out_00),
    .out_01    (out_01),
    .out_02    (out_02),
    .out_10    (out_10),
    .out_11    (out_11),
    .out_12    (out_12),
    .out_20    (out_20),
    .out_21    (out_21),
    .out_22    (out_22),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Record each handshake at the rising edge; the driver reads these at the
  // following falling edge, so it never races the block's own updates.
  always @(posedge clk) begin
    in_took  <= in_valid && !in_stall;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // Watchdog: any accepted item on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver back-pressure: at the end of each span of random length pick a new stall rate,
  // including long stretches with no stall at all and stretches of heavy stall.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(50, 600);
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 20;
        3:       stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Present one item with the current entries and exponent n; hold it until
  // the block takes it. Valid stays high on return so a burst runs back to back.
  task automatic send_item(input logic [fmp_pkg::EXP_BITS_DEF-1:0] n);
    exp_val  = n;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  // Write one register; drop valid once it has been taken.
  task automatic write_reg(input logic [fmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fmp_pkg::CFG_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
    if (idx == fmp_pkg::REG_PRIME) cur_md = (val < 2) ? 2 : int'(val);
  endtask

  // Drop valid and hold off until every predicted result item has come back.
  task automatic drain();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic fill_all(input int v);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        ent[i][j] = fmp_pkg::elem_t'(v);
  endtask

  // Mostly field elements inside (-modulus, modulus); wild items take any
  // 8-bit pattern so that every input bit toggles.
  task automatic fill_random(input bit wild);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (wild || $urandom_range(0, 19) == 0)
          ent[i][j] = fmp_pkg::elem_t'($urandom);
        else
          ent[i][j] = fmp_pkg::elem_t'(int'($urandom_range(0, 2 * cur_md - 2)) -
                                       (cur_md - 1));
  endtask

  // Exponent mix: full-width values for deep square-and-multiply chains,
  // plus short ones, powers of two, all-ones runs, zero and the top bit set.
  function automatic logic [fmp_pkg::EXP_BITS_DEF-1:0] pick_exponent();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 16'($urandom);
    if (sel < 60) return 16'($urandom_range(0, 15));
    if (sel < 75) return 16'd1 << $urandom_range(0, 15);
    if (sel < 85) return 16'((32'd1 << $urandom_range(1, 16)) - 1);
    if (sel < 90) return '0;
    return 16'h8000 | 16'($urandom);
  endfunction

  // One configuration phase: write both registers while idle, now and then
  // poke an undecoded index, then send random items in bursts with gaps.
  task automatic run_phase(input logic [fmp_pkg::CFG_W-1:0] p,
                           input logic [fmp_pkg::CFG_W-1:0] w, input int count);
    int burst;
    drain();
    write_reg(fmp_pkg::REG_PRIME, p);
    write_reg(fmp_pkg::REG_W_SQUARE, w);
    if ($urandom_range(0, 1)) write_reg(($urandom_range(0, 1)) ? REG_SPARE_A : REG_SPARE_B,
                                        7'($urandom));
    burst = $urandom_range(1, 30);
    for (int k = 0; k < count; k++) begin
      fill_random($urandom_range(0, 99) < 15);
      send_item(pick_exponent());
      burst--;
      if (burst == 0) begin
        in_valid = 1'b0;
        // sometimes wait for the block to go fully idle before resuming
        if ($urandom_range(0, 9) == 0) drain();
        else repeat ($urandom_range(1, 40)) @(negedge clk);
        burst = $urandom_range(1, 30);
      end
    end
  endtask

  initial begin
    fill_all(0);
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Reset settings: modulus 2, plain field.
    fill_all(127);
    send_item(16'h0000);          // zero exponent gives the identity
    fill_all(-128);
    send_item(16'h0001);          // exponent one passes entries through unreduced
    fill_all(1);
    send_item(16'hFFFF);
    fill_random(1'b0);
    send_item(16'h8000);          // fifteen squarings before the first one bit
    drain();

    // Largest modulus and largest w_square.
    write_reg(fmp_pkg::REG_PRIME, 7'd127);
    write_reg(fmp_pkg::REG_W_SQUARE, 7'd126);
    fill_all(-126);
    send_item(16'h0002);          // all-negative entries exercise the w_square path
    fill_all(126);
    send_item(16'h0003);
    fill_all(-128);
    ent[0][1] = 8'sd127;
    ent[2][2] = 8'sd127;
    send_item(16'hFFFF);
    fill_all(0);
    ent[0][0] = 8'sd1;
    ent[1][1] = -8'sd1;
    ent[2][2] = 8'sd2;
    send_item(16'h5555);
    fill_random(1'b0);
    send_item(16'h8000);
    fill_all(0);
    send_item(16'h0007);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        ent[i][j] = ((i + j) % 2) ? -8'sd1 : 8'sd1;
    send_item(16'hAAAA);
    fill_all(127);
    ent[1][0] = -8'sd128;
    send_item(16'h0001);
    drain();

    // Undecoded indexes, then a modulus register below two (acts as two).
    write_reg(REG_SPARE_A, 7'h7F);
    write_reg(REG_SPARE_B, 7'h55);
    write_reg(fmp_pkg::REG_PRIME, 7'd0);
    write_reg(fmp_pkg::REG_W_SQUARE, 7'd127);
    fill_random(1'b1);
    send_item(16'h0005);
    fill_random(1'b1);
    send_item(16'hFFFF);
    drain();
    write_reg(fmp_pkg::REG_PRIME, 7'd1);
    fill_random(1'b1);
    send_item(16'h0009);

    // Random phases over a spread of settings, extremes first.
    run_phase(7'd127, 7'd0, PHASE_ITEMS);
    run_phase(7'd2, 7'd1, PHASE_ITEMS);
    run_phase(7'd13, 7'd5, PHASE_ITEMS);
    run_phase(7'd127, 7'd126, PHASE_ITEMS);
    for (int ph = 0; ph < 4; ph++)
      run_phase(7'($urandom), 7'($urandom), PHASE_ITEMS);

    // Drain the last results, then allow the block's latency for strays.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fmp_pkg.sv
hdl/fmp_recip.sv
hdl/fmp_lane.sv
hdl/field_matrix_power_unit.sv
hdl/fmp_checker.sv
tb/fmp_checker.sv
tb/testbench.sv
